/* design/serial_line_assembler_unit_assert.svh */
// assertion macros for the serial line assembler
// depends on nothing; included by the top level only
`ifndef SERIAL_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`define SERIAL_LINE_ASSEMBLER_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SLA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("serial line assembler check failed");

// consequent holds in the same cycle as the antecedent
`define SLA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("serial line assembler check failed");

// consequent holds in the cycle after the antecedent
`define SLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("serial line assembler check failed");

`endif

/* design/sla_pkg.sv */
// shared types and constants for the serial line assembler
// no dependencies; used by the interfaces, the store and the top level
package sla_pkg;

	localparam int MODE_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 6;

	// command carried by each input item
	typedef enum logic [MODE_W-1:0] {
		MODE_RX      = 2'd0,
		MODE_READ    = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_POP     = 2'd3
	} mode_t;

	// special characters of the line editor
	localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_ESCAPE    = 8'h5C;

endpackage

/* design/sla_ifs.sv */
// valid/ready channel interfaces for the serial line assembler
// depends on sla_pkg for field widths
interface sla_in_if;
	logic                           valid;
	logic                           ready;
	logic [sla_pkg::MODE_W-1:0]     mode;
	logic [sla_pkg::BYTE_W-1:0]     rx_byte;
	logic [sla_pkg::INDEX_W-1:0]    read_index;

	modport source (output valid, mode, rx_byte, read_index, input ready);
	modport sink   (input valid, mode, rx_byte, read_index, output ready);
endinterface

interface sla_out_if;
	logic                           valid;
	logic                           ready;
	logic [sla_pkg::BYTE_W-1:0]     data;
	logic                           line_ready;
	logic                           rx_overflow;
	logic [sla_pkg::COUNT_W-1:0]    char_count;
	logic                           ring_empty;
	logic                           byte_dropped;

	modport source (output valid, data, line_ready, rx_overflow, char_count, ring_empty,
		byte_dropped, input ready);
	modport sink   (input valid, data, line_ready, rx_overflow, char_count, ring_empty,
		byte_dropped, output ready);
endinterface

/* design/sla_store.sv */
// byte store shared by the line assembler and the ring
// one write and one registered read per cycle, write-to-read bypass; uses sla_pkg
module sla_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [sla_pkg::BYTE_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [sla_pkg::BYTE_W-1:0] rd_data
);

	logic [sla_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]           valid_q;
	logic [sla_pkg::BYTE_W-1:0] rd_mem_s2;
	logic [sla_pkg::BYTE_W-1:0] fwd_data_s2;
	logic                       rd_valid_s2;
	logic                       fwd_hit_s2;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_s2   <= mem[rd_addr];
			fwd_data_s2 <= wr_data;
		end
	end

	// entries never written read as zero; same-edge write is bypassed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s2 <= 1'b0;
			fwd_hit_s2  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s2 <= valid_q[rd_addr];
				fwd_hit_s2  <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// read data select
	always_comb begin
		if (fwd_hit_s2) begin
			rd_data = fwd_data_s2;
		end else if (rd_valid_s2) begin
			rd_data = rd_mem_s2;
		end else begin
			rd_data = '0;
		end
	end

endmodule

/* design/serial_line_assembler_unit.sv */
// Serial line assembler: builds command lines from received bytes, or passes
// bytes through a ring, both held in one shared byte store.
// Channels: req (sink) carries mode, rx_byte and read_index; rsp (source)
// carries exactly one result item for every request item. Both use
// valid/ready, an item moves on an edge where both are high.
// cfg_we/cfg_wdata write the passthrough bit; write it only while idle.
// A request passes through the request stage, the store read stage and the
// output register in turn. Throughput: one item per cycle while rsp.ready
// holds. The store read issued in the request stage takes its address from
// the counters just updated by the item ahead, so back-to-back receive, read
// and pop items run without bubbles.
// Reset: counters and flags clear, store entries read as zero until written
// (a valid bit per entry clears at once, no clearing pass).
// Stall: when rsp.ready is low the output holds; up to three items stay in
// flight before req.ready drops.
module serial_line_assembler_unit #(
	parameter int STORE_DEPTH = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	sla_in_if.sink    req,
	sla_out_if.source rsp,
	input  logic   cfg_we,
	input  logic   cfg_wdata
);

	`include "serial_line_assembler_unit_assert.svh"

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int IW = sla_pkg::INDEX_W;
	localparam int CW = sla_pkg::COUNT_W;
	localparam logic [AW-1:0]    FULL_COUNT = AW'(STORE_DEPTH - 1);
	localparam logic [AW-1:0]    LAST_POS   = AW'(STORE_DEPTH - 2);
	localparam logic [AW+IW-1:0] DEPTH_WIDE = (AW + IW)'(STORE_DEPTH);

	// pipeline registers
	logic                        s1_valid_q;
	sla_pkg::mode_t              s1_mode;
	logic [sla_pkg::BYTE_W-1:0]  s1_byte;
	logic [IW-1:0]               s1_index;
	logic                        s2_valid_q;
	sla_pkg::mode_t              s2_mode;
	logic [sla_pkg::BYTE_W-1:0]  s2_byte;
	logic [IW-1:0]               s2_index;

	// architectural state
	logic                        passthrough_q;
	logic [AW-1:0]               count_q;
	logic                        ready_q;
	logic                        ovf_q;
	logic [AW-1:0]               wpos_q;
	logic [AW-1:0]               rpos_q;

	// output register
	logic                        out_valid_q;
	logic [sla_pkg::BYTE_W-1:0]  out_data_q;
	logic                        out_ready_flag_q;
	logic                        out_ovf_q;
	logic [CW-1:0]               out_count_q;
	logic                        out_empty_q;
	logic                        out_dropped_q;

	// handshakes and next state
	logic                        out_free;
	logic                        s2_free;
	logic                        s2_go;
	logic                        s1_go;
	logic                        in_go;
	logic [AW-1:0]               count_n;
	logic                        ready_n;
	logic                        ovf_n;
	logic [AW-1:0]               wpos_n;
	logic [AW-1:0]               rpos_n;
	logic [AW-1:0]               wpos_inc;
	logic [AW-1:0]               rpos_inc;
	logic [sla_pkg::BYTE_W-1:0]  data_n;
	logic                        dropped_n;
	logic                        escaped;
	logic                        wr_req;
	logic                        store_we;
	logic [AW-1:0]               wr_addr;
	logic [sla_pkg::BYTE_W-1:0]  wr_data;
	logic [AW-1:0]               rd_addr;
	logic [sla_pkg::BYTE_W-1:0]  rd_data;
	logic [AW+IW-1:0]            idx_ext_s1;
	logic [AW+IW-1:0]            idx_ext_s2;
	logic [AW+CW-1:0]            count_ext;

	// flow control: each stage moves when the one after it frees up
	assign out_free = !out_valid_q || rsp.ready;
	assign s2_free  = !s2_valid_q || out_free;
	assign s2_go    = s2_valid_q && out_free;
	assign s1_go    = s1_valid_q && s2_free;
	assign req.ready = !s1_valid_q || s2_free;
	assign in_go    = req.valid && req.ready;

	// index widening for store addressing and the range check
	assign idx_ext_s1 = {{AW{1'b0}}, s1_index};
	assign idx_ext_s2 = {{AW{1'b0}}, s2_index};

	// ring pointer advance with wrap
	assign wpos_inc = (wpos_q == LAST_POS) ? '0 : wpos_q + 1'b1;
	assign rpos_inc = (rpos_q == LAST_POS) ? '0 : rpos_q + 1'b1;

	// last held character is a backslash
	assign escaped = (count_q != '0) && (rd_data == sla_pkg::CH_ESCAPE);

	// second stage: decide the item with the store data in hand
	always_comb begin
		count_n   = count_q;
		ready_n   = ready_q;
		ovf_n     = ovf_q;
		wpos_n    = wpos_q;
		rpos_n    = rpos_q;
		data_n    = '0;
		dropped_n = 1'b0;
		wr_req    = 1'b0;
		wr_addr   = count_q;
		wr_data   = s2_byte;
		if (s2_valid_q) begin
			case (s2_mode)
				sla_pkg::MODE_RX: begin
					if (passthrough_q) begin
						if (wpos_inc == rpos_q) begin
							dropped_n = 1'b1;
						end else begin
							wr_req  = 1'b1;
							wr_addr = wpos_q;
							wpos_n  = wpos_inc;
						end
					end else if (ready_q) begin
						ovf_n     = 1'b1;
						dropped_n = 1'b1;
					end else if (s2_byte == sla_pkg::CH_BACKSPACE) begin
						if (count_q != '0) begin
							count_n = count_q - 1'b1;
						end
					end else if (s2_byte == sla_pkg::CH_CR && !escaped) begin
						wr_req  = 1'b1;
						wr_data = '0;
						count_n = '0;
						ready_n = 1'b1;
					end else if (count_q < FULL_COUNT) begin
						wr_req  = 1'b1;
						count_n = count_q + 1'b1;
					end else begin
						dropped_n = 1'b1;
					end
				end
				sla_pkg::MODE_READ: begin
					if (idx_ext_s2 < DEPTH_WIDE) begin
						data_n = rd_data;
					end
				end
				sla_pkg::MODE_RELEASE: begin
					ready_n = 1'b0;
				end
				sla_pkg::MODE_POP: begin
					if (rpos_q != wpos_q) begin
						data_n = rd_data;
						rpos_n = rpos_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign store_we = wr_req && s2_go;

	// first stage: store address from the state after the item ahead
	always_comb begin
		case (s1_mode)
			sla_pkg::MODE_RX:   rd_addr = count_n - 1'b1;
			sla_pkg::MODE_READ: rd_addr = idx_ext_s1[AW-1:0];
			sla_pkg::MODE_POP:  rd_addr = rpos_n;
			default:            rd_addr = '0;
		endcase
	end

	sla_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (store_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (s1_go),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// pipeline payload, no reset
	always_ff @(posedge clk) begin
		if (in_go) begin
			s1_mode  <= sla_pkg::mode_t'(req.mode);
			s1_byte  <= req.rx_byte;
			s1_index <= req.read_index;
		end
		if (s1_go) begin
			s2_mode  <= s1_mode;
			s2_byte  <= s1_byte;
			s2_index <= s1_index;
		end
	end

	assign count_ext = {{CW{1'b0}}, count_n};

	// control state, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q       <= 1'b0;
			s2_valid_q       <= 1'b0;
			out_valid_q      <= 1'b0;
			passthrough_q    <= 1'b0;
			count_q          <= '0;
			ready_q          <= 1'b0;
			ovf_q            <= 1'b0;
			wpos_q           <= '0;
			rpos_q           <= '0;
			out_data_q       <= '0;
			out_ready_flag_q <= 1'b0;
			out_ovf_q        <= 1'b0;
			out_count_q      <= '0;
			out_empty_q      <= 1'b0;
			out_dropped_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				passthrough_q <= cfg_wdata;
			end
			if (in_go) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				s2_valid_q <= 1'b1;
			end else if (s2_go) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_go) begin
				out_valid_q      <= 1'b1;
				count_q          <= count_n;
				ready_q          <= ready_n;
				ovf_q            <= ovf_n;
				wpos_q           <= wpos_n;
				rpos_q           <= rpos_n;
				out_data_q       <= data_n;
				out_ready_flag_q <= ready_n;
				out_ovf_q        <= ovf_n;
				out_count_q      <= count_ext[CW-1:0];
				out_empty_q      <= (rpos_n == wpos_n);
				out_dropped_q    <= dropped_n;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.data         = out_data_q;
	assign rsp.line_ready   = out_ready_flag_q;
	assign rsp.rx_overflow  = out_ovf_q;
	assign rsp.char_count   = out_count_q;
	assign rsp.ring_empty   = out_empty_q;
	assign rsp.byte_dropped = out_dropped_q;

	// checks
	`SLA_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL_COUNT)
	`SLA_ASSERT_ALWAYS(a_ring_bound, clk, arst_n, (wpos_q <= LAST_POS) && (rpos_q <= LAST_POS))
	`SLA_ASSERT_IMPLIES(a_no_write_on_drop, clk, arst_n, store_we, !dropped_n)
	`SLA_ASSERT_NEXT(a_held_line_frozen, clk, arst_n, s2_go && (s2_mode == sla_pkg::MODE_RX) && !passthrough_q && ready_q, (count_q == $past(count_q)) && ready_q)

endmodule

/* verif/serial_line_assembler_unit_checker.sv */
`timescale 1ns / 100ps
// result checker for the serial line assembler: keeps its own line editor and ring
// state, predicts one result per request item and compares fields in order
// depends on sla_pkg and the channel interfaces in sla_ifs.sv
module serial_line_assembler_unit_checker #(
	parameter int STORE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	sla_in_if    req,
	sla_out_if   rsp,
	input  logic cfg_we,
	input  logic cfg_wdata,
	output int   mismatch_count,
	output int   results_pending
);
	import sla_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               line_ready;
		logic               rx_overflow;
		logic [COUNT_W-1:0] char_count;
		logic               ring_empty;
		logic               byte_dropped;
	} line_result_t;

	// predicted editor and ring state
	logic [BYTE_W-1:0]  line_mem [STORE_DEPTH];
	logic [COUNT_W-1:0] held_chars;
	logic               line_waiting;
	logic               overflow_seen;
	logic [COUNT_W-1:0] ring_wr;
	logic [COUNT_W-1:0] ring_rd;
	logic               passthrough;

	line_result_t expected_results [$];
	int           result_num;

	// ring positions wrap one short of the store depth
	function automatic logic [COUNT_W-1:0] ring_advance(input logic [COUNT_W-1:0] pos);
		int nxt;
		nxt = int'(pos) + 1;
		return (nxt >= STORE_DEPTH - 1) ? '0 : COUNT_W'(nxt);
	endfunction

	// apply one command to the predicted state and build its result
	task automatic apply_command(input mode_t cmd, input logic [BYTE_W-1:0] rx,
		input logic [INDEX_W-1:0] idx, output line_result_t res);
		logic [BYTE_W-1:0]  rd_byte;
		logic               dropped;
		logic [COUNT_W-1:0] nxt;
		rd_byte = '0;
		dropped = 1'b0;
		case (cmd)
			MODE_RX: begin
				if (passthrough) begin
					nxt = ring_advance(ring_wr);
					if (nxt == ring_rd) begin
						dropped = 1'b1;
					end else begin
						line_mem[ring_wr] = rx;
						ring_wr = nxt;
					end
				end else if (line_waiting) begin
					overflow_seen = 1'b1;
					dropped = 1'b1;
				end else if (rx == CH_BACKSPACE) begin
					if (held_chars != 0)
						held_chars = held_chars - 1'b1;
				end else if (rx == CH_CR &&
					(held_chars == 0 || line_mem[held_chars - 1'b1] != CH_ESCAPE)) begin
					// unescaped return closes the line with a zero byte
					line_mem[held_chars] = '0;
					held_chars = '0;
					line_waiting = 1'b1;
				end else if (int'(held_chars) < STORE_DEPTH - 1) begin
					line_mem[held_chars] = rx;
					held_chars = held_chars + 1'b1;
				end else begin
					dropped = 1'b1;
				end
			end
			MODE_READ: rd_byte = line_mem[idx];
			MODE_RELEASE: line_waiting = 1'b0;
			MODE_POP: begin
				if (ring_rd != ring_wr) begin
					rd_byte = line_mem[ring_rd];
					ring_rd = ring_advance(ring_rd);
				end
			end
		endcase
		res = '{rd_byte, line_waiting, overflow_seen, held_chars, ring_rd == ring_wr, dropped};
	endtask

	task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
		input logic [BYTE_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d: %s expected 0x%0h, got 0x%0h", result_num, field,
					want, got);
		end
	endtask

	// watch both channels; compare before predicting so order within an edge is fixed
	always @(posedge clk or negedge arst_n) begin : monitor
		line_result_t want;
		line_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				line_mem[i] = '0;
			held_chars = '0;
			line_waiting = 1'b0;
			overflow_seen = 1'b0;
			ring_wr = '0;
			ring_rd = '0;
			passthrough = 1'b0;
			expected_results.delete();
			result_num = 0;
			mismatch_count = 0;
			results_pending = 0;
		end else begin
			if (cfg_we)
				passthrough = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.data, rsp.line_ready, rsp.rx_overflow, rsp.char_count,
					rsp.ring_empty, rsp.byte_dropped};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d arrived with no request waiting", result_num);
				end else begin
					want = expected_results.pop_front();
					check_field("data", want.data, got.data);
					check_field("line_ready", want.line_ready, got.line_ready);
					check_field("rx_overflow", want.rx_overflow, got.rx_overflow);
					check_field("char_count", want.char_count, got.char_count);
					check_field("ring_empty", want.ring_empty, got.ring_empty);
					check_field("byte_dropped", want.byte_dropped, got.byte_dropped);
				end
				result_num++;
			end
			if (req.valid && req.ready) begin
				apply_command(mode_t'(req.mode), req.rx_byte, req.read_index, want);
				expected_results.push_back(want);
			end
			results_pending = expected_results.size();
		end
	end
endmodule

/* verif/serial_line_assembler_unit_tb.sv */
`timescale 1ns / 100ps
// top of the serial line assembler testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict
// depends on sla_pkg, sla_ifs.sv, the block and serial_line_assembler_unit_checker
module serial_line_assembler_unit_tb;
	import sla_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_RUN  = 280;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   mismatch_count;
	int   results_pending;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   items_sent;
	int   stall_cycles;

	sla_in_if  req ();
	sla_out_if rsp ();

	always #2 clk = ~clk;

	serial_line_assembler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	serial_line_assembler_unit_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// response back-pressure
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// present one item at a falling edge and hold it until accepted
	task automatic send_item(input mode_t cmd, input logic [BYTE_W-1:0] rx,
		input logic [INDEX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.mode = cmd;
		req.rx_byte = rx;
		req.read_index = idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// unused fields carry random values
	task automatic send_rx(input logic [BYTE_W-1:0] rx);
		send_item(MODE_RX, rx, INDEX_W'($urandom));
	endtask

	task automatic send_read(input logic [INDEX_W-1:0] idx);
		send_item(MODE_READ, BYTE_W'($urandom), idx);
	endtask

	task automatic send_release();
		send_item(MODE_RELEASE, BYTE_W'($urandom), INDEX_W'($urandom));
	endtask

	task automatic send_pop();
		send_item(MODE_POP, BYTE_W'($urandom), INDEX_W'($urandom));
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 6))
			send_item(mode_t'($urandom_range(3)), BYTE_W'($urandom), INDEX_W'($urandom));
	endtask

	// hold off until every result is back
	task automatic wait_results();
		req.valid = 1'b0;
		while (results_pending != 0)
			@(negedge clk);
	endtask

	task automatic set_passthrough(input logic on);
		wait_results();
		cfg_we = 1'b1;
		cfg_wdata = on;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// line text, mostly printable, with optional backspaces and escaped returns
	task automatic send_line_text(input int len, input bit with_edits);
		int r;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(15);
			if (with_edits && r == 0) begin
				send_rx(CH_BACKSPACE);
			end else if (with_edits && r == 1) begin
				send_rx(CH_ESCAPE);
				send_rx(CH_CR);
			end else if (r == 2) begin
				send_rx(BYTE_W'($urandom));
			end else begin
				send_rx(BYTE_W'($urandom_range(8'h20, 8'h7e)));
			end
		end
	endtask

	// line mode: whole lines with reads and release, some overflow, some noise
	task automatic run_line_traffic(input int goal);
		int k;
		int len;
		int top_idx;
		send_release();
		send_line_text(66, 1'b0);
		send_rx(CH_CR);
		send_read(INDEX_W'(63));
		send_release();
		while (items_sent < goal) begin
			k = $urandom_range(9);
			if (k <= 6) begin
				if ($urandom_range(9) != 0)
					send_release();
				len = ($urandom_range(19) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
				send_line_text(len, 1'b1);
				if ($urandom_range(9) != 0)
					send_rx(CH_CR);
				top_idx = (len + 1 > 63) ? 63 : len + 1;
				repeat ($urandom_range(1, 4))
					send_read(INDEX_W'($urandom_range(0, top_idx)));
				if ($urandom_range(4) == 0)
					repeat ($urandom_range(1, 3))
						send_rx(BYTE_W'($urandom));
			end else begin
				send_noise();
			end
		end
	endtask

	// passthrough: fill the ring past full, drain past empty, then mixed bursts
	task automatic run_ring_traffic(input int goal);
		int k;
		repeat (66)
			send_rx(BYTE_W'($urandom));
		repeat (64)
			send_pop();
		while (items_sent < goal) begin
			k = $urandom_range(9);
			if (k <= 6) begin
				repeat ((k == 0) ? $urandom_range(40, 66) : $urandom_range(0, 8))
					send_rx(BYTE_W'($urandom));
				repeat ($urandom_range(0, 10))
					send_pop();
				if ($urandom_range(3) == 0)
					send_read(INDEX_W'($urandom));
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin
		int send_pcts [3];
		int recv_pcts [3];
		send_pcts = '{30, 63, 0};
		recv_pcts = '{63, 30, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req.valid = 1'b0;
		req.mode = MODE_RX;
		req.rx_byte = '0;
		req.read_index = '0;
		items_sent = 0;
		stall_cycles = 0;
		send_idle_pct = send_pcts[0];
		recv_idle_pct = recv_pcts[0];
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// line editor corner cases
		send_pop();
		send_read(INDEX_W'(63));
		send_read(INDEX_W'(0));
		send_rx(CH_CR);
		send_rx(8'hff);
		send_release();
		send_rx(CH_BACKSPACE);
		send_rx(8'h00);
		send_rx(CH_ESCAPE);
		send_rx(CH_CR);
		send_rx(CH_BACKSPACE);
		send_rx(CH_BACKSPACE);
		send_rx(CH_CR);
		send_read(INDEX_W'(1));
		send_read(INDEX_W'(2));
		send_release();

		// ring corner cases, ring sharing the line store
		set_passthrough(1'b1);
		send_rx(8'hab);
		send_rx(8'h55);
		send_read(INDEX_W'(0));
		send_pop();
		send_pop();
		send_pop();
		send_release();

		// random traffic under three back-pressure mixes, both modes each
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = send_pcts[p];
			recv_idle_pct = recv_pcts[p];
			set_passthrough(1'b0);
			run_line_traffic(items_sent + ITEMS_PER_RUN);
			set_passthrough(1'b1);
			run_ring_traffic(items_sent + ITEMS_PER_RUN);
		end

		wait_results();
		repeat (8)
			@(negedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
